// File: rtl/core/kfq_pkg.sv
// ----------------------------------------------------------------------------
// kfq_pkg
// Shared types and constants for the keyed FIFO with cancel by key.
// ----------------------------------------------------------------------------
package kfq_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int GRP   = 8;
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
  localparam int PAD   = NGRP * GRP;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  team_a;
    logic [7:0]  team_b;
    logic [15:0] date;
    logic [1:0]  prio;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_LIST   = 3'd1,
    CMD_POP    = 3'd2,
    CMD_CANCEL = 3'd3,
    CMD_REDATE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    KIND_FINAL  = 2'd0,
    KIND_SEMI   = 2'd1,
    KIND_LEAGUE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_WRAP,
    CELL_DATE
  } cell_op_t;

  typedef enum logic [2:0] {
    MD_HOLD,
    MD_PUSH,
    MD_POP,
    MD_ROTATE,
    MD_CANCEL,
    MD_REDATE
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIST,
    S_GROUP,
    S_APPLY
  } state_t;

  function automatic kind_t kind_of(input logic [1:0] prio);
    kind_t k;
    if (prio == 2'd1) begin
      k = KIND_FINAL;
    end else if (prio == 2'd2) begin
      k = KIND_SEMI;
    end else begin
      k = KIND_LEAGUE;
    end
    return k;
  endfunction

endpackage

// File: rtl/core/kfq_cell.sv
// ----------------------------------------------------------------------------
// kfq_cell
// One queue slot: holds an entry, loads, shifts from its neighbour or from
// the head, rewrites its date, and compares its key.
// ----------------------------------------------------------------------------
module kfq_cell (
  input  logic              clk,
  input  kfq_pkg::cell_op_t op,
  input  kfq_pkg::entry_t   push_entry,
  input  kfq_pkg::entry_t   right_entry,
  input  kfq_pkg::entry_t   head_entry,
  input  logic [15:0]       new_date,
  input  logic [15:0]       cmp_key,
  output kfq_pkg::entry_t   entry,
  output logic              match
);

  kfq_pkg::entry_t entry_r;
  kfq_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    case (op)
      kfq_pkg::CELL_LOAD:  entry_nxt = push_entry;
      kfq_pkg::CELL_SHIFT: entry_nxt = right_entry;
      kfq_pkg::CELL_WRAP:  entry_nxt = head_entry;
      kfq_pkg::CELL_DATE:  entry_nxt.date = new_date;
      default:             entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r.key == cmp_key);

endmodule

// File: rtl/core/kfq_prefix.sv
// ----------------------------------------------------------------------------
// kfq_prefix
// Registered first-match search over the cell match flags, in groups.
// ----------------------------------------------------------------------------
module kfq_prefix (
  input  logic                      clk,
  input  logic                      load,
  input  logic [kfq_pkg::DEPTH-1:0] match_in,
  output logic [kfq_pkg::DEPTH-1:0] first_hot,
  output logic [kfq_pkg::DEPTH-1:0] incl_hot,
  output logic                      any
);

  logic [kfq_pkg::PAD-1:0]  match_r;
  logic [kfq_pkg::NGRP-1:0] grp_any;
  logic [kfq_pkg::NGRP-1:0] grp_before_nxt;
  logic [kfq_pkg::NGRP-1:0] grp_before_r;
  logic                     any_r;

  always_ff @(posedge clk) begin
    if (load) begin
      match_r <= kfq_pkg::PAD'(match_in);
    end
    grp_before_r <= grp_before_nxt;
    any_r        <= |match_r;
  end

  always_comb begin
    for (int g = 0; g < kfq_pkg::NGRP; g++) begin
      grp_any[g] = |match_r[g*kfq_pkg::GRP +: kfq_pkg::GRP];
    end
    grp_before_nxt[0] = 1'b0;
    for (int g = 1; g < kfq_pkg::NGRP; g++) begin
      grp_before_nxt[g] = grp_before_nxt[g-1] | grp_any[g-1];
    end
  end

  for (genvar i = 0; i < kfq_pkg::DEPTH; i++) begin : g_bit
    localparam int G    = i / kfq_pkg::GRP;
    localparam int BASE = G * kfq_pkg::GRP;
    logic acc;
    always_comb begin
      acc = grp_before_r[G];
      for (int j = 0; j < kfq_pkg::GRP; j++) begin
        if (BASE + j < i) begin
          acc = acc | match_r[BASE + j];
        end
      end
    end
    assign incl_hot[i]  = acc | match_r[i];
    assign first_hot[i] = match_r[i] & ~acc;
  end

  assign any = any_r;

endmodule

// File: rtl/core/fifo_with_cancel_by_key.sv
// ----------------------------------------------------------------------------
// fifo_with_cancel_by_key
// Ordered queue of entries in a row of cells with push, list, pop, cancel
// by key and change of date by key.
//
//   channel | ports                                 | handshake
//   --------+---------------------------------------+--------------------------
//   input   | in_command .. in_priority_req         | start & !busy
//   result  | out_status .. out_last                | out_valid, one cycle
//
// Push, pop and commands on an empty queue: result the cycle after start.
// List: one word per cycle from the head while the row rotates, count words.
// Cancel and change date: key compare, group search, then apply.
// Reset clears the count and control only; no sweep of the cells.
// Results cannot be stalled; busy holds off new commands.
// ----------------------------------------------------------------------------
module fifo_with_cancel_by_key (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_match_key,
  input  logic [7:0]  in_team_a,
  input  logic [7:0]  in_team_b,
  input  logic [15:0] in_date_code,
  input  logic [1:0]  in_priority_req,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_key,
  output logic [7:0]  out_team_a,
  output logic [7:0]  out_team_b,
  output logic [15:0] out_date,
  output logic [1:0]  out_kind,
  output logic        out_last
);

  kfq_pkg::state_t              state_r, state_nxt;
  logic [kfq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [kfq_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  kfq_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [15:0]                  date_r, date_nxt;
  logic                         out_valid_r, out_valid_nxt;
  kfq_pkg::stat_t               status_r, status_nxt;
  kfq_pkg::entry_t              word_r, word_nxt;
  kfq_pkg::kind_t               kind_r, kind_nxt;
  logic                         last_r, last_nxt;

  kfq_pkg::mode_t               mode;
  logic                         load_match;
  kfq_pkg::entry_t              push_entry;
  kfq_pkg::entry_t              ent [kfq_pkg::DEPTH];
  kfq_pkg::cell_op_t            ops [kfq_pkg::DEPTH];
  logic [kfq_pkg::DEPTH-1:0]    cell_match;
  logic [kfq_pkg::DEPTH-1:0]    match_vec;
  logic [kfq_pkg::DEPTH-1:0]    first_hot;
  logic [kfq_pkg::DEPTH-1:0]    incl_hot;
  logic                         any_hit;

  assign push_entry = '{key: in_match_key, team_a: in_team_a, team_b: in_team_b,
                        date: in_date_code, prio: in_priority_req};

  for (genvar i = 0; i < kfq_pkg::DEPTH; i++) begin : g_cell
    kfq_pkg::entry_t right;
    if (i == kfq_pkg::DEPTH - 1) begin : g_end
      assign right = ent[i];
    end else begin : g_mid
      assign right = ent[i+1];
    end

    always_comb begin
      case (mode)
        kfq_pkg::MD_PUSH:
          ops[i] = (count_r == kfq_pkg::CNT_W'(i)) ? kfq_pkg::CELL_LOAD : kfq_pkg::CELL_HOLD;
        kfq_pkg::MD_POP:
          ops[i] = kfq_pkg::CELL_SHIFT;
        kfq_pkg::MD_ROTATE:
          if (count_r == kfq_pkg::CNT_W'(i + 1)) begin
            ops[i] = kfq_pkg::CELL_WRAP;
          end else if (kfq_pkg::CNT_W'(i + 1) < count_r) begin
            ops[i] = kfq_pkg::CELL_SHIFT;
          end else begin
            ops[i] = kfq_pkg::CELL_HOLD;
          end
        kfq_pkg::MD_CANCEL:
          ops[i] = incl_hot[i] ? kfq_pkg::CELL_SHIFT : kfq_pkg::CELL_HOLD;
        kfq_pkg::MD_REDATE:
          ops[i] = first_hot[i] ? kfq_pkg::CELL_DATE : kfq_pkg::CELL_HOLD;
        default:
          ops[i] = kfq_pkg::CELL_HOLD;
      endcase
    end

    kfq_cell u_cell (
      .clk         (clk),
      .op          (ops[i]),
      .push_entry  (push_entry),
      .right_entry (right),
      .head_entry  (ent[0]),
      .new_date    (date_r),
      .cmp_key     (in_match_key),
      .entry       (ent[i]),
      .match       (cell_match[i])
    );

    assign match_vec[i] = cell_match[i] & (kfq_pkg::CNT_W'(i) < count_r);
  end

  kfq_prefix u_prefix (
    .clk       (clk),
    .load      (load_match),
    .match_in  (match_vec),
    .first_hot (first_hot),
    .incl_hot  (incl_hot),
    .any       (any_hit)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    cmd_nxt       = cmd_r;
    date_nxt      = date_r;
    out_valid_nxt = 1'b0;
    status_nxt    = kfq_pkg::STAT_OK;
    word_nxt      = '0;
    kind_nxt      = kfq_pkg::KIND_FINAL;
    last_nxt      = 1'b0;
    mode          = kfq_pkg::MD_HOLD;
    load_match    = 1'b0;
    unique case (state_r)
      kfq_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt  = kfq_pkg::cmd_t'(in_command);
          date_nxt = in_date_code;
          case (in_command)
            kfq_pkg::CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              last_nxt      = 1'b1;
              if (count_r == kfq_pkg::CNT_W'(kfq_pkg::DEPTH)) begin
                status_nxt = kfq_pkg::STAT_FULL;
              end else begin
                mode      = kfq_pkg::MD_PUSH;
                count_nxt = count_r + kfq_pkg::CNT_W'(1);
              end
            end
            kfq_pkg::CMD_LIST: begin
              out_valid_nxt = 1'b1;
              if (count_r == '0) begin
                status_nxt = kfq_pkg::STAT_EMPTY;
                last_nxt   = 1'b1;
              end else begin
                mode     = kfq_pkg::MD_ROTATE;
                word_nxt = ent[0];
                kind_nxt = kfq_pkg::kind_of(ent[0].prio);
                last_nxt = (count_r == kfq_pkg::CNT_W'(1));
                rem_nxt  = count_r - kfq_pkg::CNT_W'(1);
                if (count_r != kfq_pkg::CNT_W'(1)) begin
                  state_nxt = kfq_pkg::S_LIST;
                end
              end
            end
            kfq_pkg::CMD_POP: begin
              out_valid_nxt = 1'b1;
              last_nxt      = 1'b1;
              if (count_r == '0) begin
                status_nxt = kfq_pkg::STAT_EMPTY;
              end else begin
                mode      = kfq_pkg::MD_POP;
                word_nxt  = ent[0];
                kind_nxt  = kfq_pkg::kind_of(ent[0].prio);
                count_nxt = count_r - kfq_pkg::CNT_W'(1);
              end
            end
            kfq_pkg::CMD_CANCEL, kfq_pkg::CMD_REDATE: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                last_nxt      = 1'b1;
                status_nxt    = kfq_pkg::STAT_EMPTY;
              end else begin
                load_match = 1'b1;
                state_nxt  = kfq_pkg::S_GROUP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      kfq_pkg::S_LIST: begin
        mode          = kfq_pkg::MD_ROTATE;
        out_valid_nxt = 1'b1;
        word_nxt      = ent[0];
        kind_nxt      = kfq_pkg::kind_of(ent[0].prio);
        last_nxt      = (rem_r == kfq_pkg::CNT_W'(1));
        rem_nxt       = rem_r - kfq_pkg::CNT_W'(1);
        if (rem_r == kfq_pkg::CNT_W'(1)) begin
          state_nxt = kfq_pkg::S_IDLE;
        end
      end
      kfq_pkg::S_GROUP: begin
        state_nxt = kfq_pkg::S_APPLY;
      end
      kfq_pkg::S_APPLY: begin
        out_valid_nxt = 1'b1;
        last_nxt      = 1'b1;
        state_nxt     = kfq_pkg::S_IDLE;
        if (!any_hit) begin
          status_nxt = kfq_pkg::STAT_NOT_FOUND;
        end else if (cmd_r == kfq_pkg::CMD_CANCEL) begin
          mode      = kfq_pkg::MD_CANCEL;
          count_nxt = count_r - kfq_pkg::CNT_W'(1);
        end else begin
          mode = kfq_pkg::MD_REDATE;
        end
      end
      default: begin
        state_nxt = kfq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kfq_pkg::S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    date_r   <= date_nxt;
    status_r <= status_nxt;
    word_r   <= word_nxt;
    kind_r   <= kind_nxt;
    last_r   <= last_nxt;
  end

  assign busy       = (state_r != kfq_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_key    = word_r.key;
  assign out_team_a = word_r.team_a;
  assign out_team_b = word_r.team_b;
  assign out_date   = word_r.date;
  assign out_kind   = kind_r;
  assign out_last   = last_r;

endmodule

// File: rtl/core/kfq_checker.sv
// ----------------------------------------------------------------------------
// kfq_checker
// Port-level checks for the keyed FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module kfq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_command,
  input logic [15:0] in_match_key,
  input logic [7:0]  in_team_a,
  input logic [7:0]  in_team_b,
  input logic [15:0] in_date_code,
  input logic [1:0]  in_priority_req,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [15:0] out_key,
  input logic [7:0]  out_team_a,
  input logic [7:0]  out_team_b,
  input logic [15:0] out_date,
  input logic [1:0]  out_kind,
  input logic        out_last
);

  // error words end the command and carry no entry
  a_err_word : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != kfq_pkg::STAT_OK |->
      out_last && out_key == 16'd0 && out_team_a == 8'd0 && out_team_b == 8'd0 &&
      out_date == 16'd0 && out_kind == 2'd0)
    else $error("error word carries data or is not last");

  // push and pop answer in the next cycle with a single word
  a_quick : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == kfq_pkg::CMD_PUSH || in_command == kfq_pkg::CMD_POP)
      |=> out_valid && out_last)
    else $error("push or pop did not answer in one cycle");

  // a list stream has no gaps
  a_stream : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap in list stream");

  // no command is taken while a list stream is still running
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("idle during list stream");

  a_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 2'd3)
    else $error("unknown kind code");

endmodule

bind fifo_with_cancel_by_key kfq_checker u_kfq_checker (.*);
